// File: hw/rtl/positional_array_list_defines.svh
// Assertion macros used by the positional array list sequencer.
`ifndef POSITIONAL_ARRAY_LIST_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define PAL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define PAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/pal_pkg.sv
// Shared types and constants of the positional array list.
`default_nettype none

package pal_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int ACT_W  = 2;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_READ   = 2'd0,
    ACT_LOCATE = 2'd1,
    ACT_INSERT = 2'd2,
    ACT_DELETE = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef struct packed {
    status_t            status;
    logic [POS_W-1:0]   found;
    logic [VAL_W-1:0]   rdval;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/pal_mem.sv
// Entry store: one write port and one registered read port.
`default_nettype none

module pal_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/pal_seq.sv
// Sequencer: walks the entry store one word a cycle for read, locate, insert, delete.
`default_nettype none
`include "positional_array_list_defines.svh"

module pal_seq
  import pal_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire action_t               in_action,
  input  wire logic [POS_W-1:0]      in_position,
  input  wire logic [VAL_W-1:0]      in_value,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output result_t                    res,
  output logic      [CW-1:0]         count,
  output logic                       mem_we,
  output logic      [AW-1:0]         mem_waddr,
  output logic      [DATA_WIDTH-1:0] mem_wdata,
  output logic      [AW-1:0]         mem_raddr,
  input  wire logic [DATA_WIDTH-1:0] mem_rdata
);

  // Compare width: holds a position, a count and one more without wrap.
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_SCAN = 6'b000100,
    S_MOVE = 6'b001000,
    S_PUT  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t                state, state_next;
  action_t               act, act_next;
  logic [POS_W-1:0]      pos, pos_next;
  logic [DATA_WIDTH-1:0] val, val_next;
  logic [AW-1:0]         idx, idx_next;
  logic [CW-1:0]         count_next;
  result_t               res_next;

  logic [PW-1:0] in_pos_x, pos_x, cnt_x, idx_x;
  logic          rd_bad, ins_bad, full;

  assign in_pos_x = PW'(in_position);
  assign pos_x    = PW'(pos);
  assign cnt_x    = PW'(count);
  assign idx_x    = PW'(idx);

  assign rd_bad  = (in_position == '0) || (in_pos_x > cnt_x);
  assign ins_bad = (in_position == '0) || (in_pos_x > cnt_x + PW'(1));
  assign full    = (count == CW'(CAPACITY));

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    state_next = state;
    act_next   = act;
    pos_next   = pos;
    val_next   = val;
    idx_next   = idx;
    count_next = count;
    res_next   = res;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = mem_rdata;
    mem_raddr  = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          act_next = in_action;
          pos_next = in_position;
          val_next = DATA_WIDTH'($unsigned(in_value));
          res_next = '{status: ST_OK, found: '0, rdval: '0};
          unique case (in_action)
            ACT_READ: begin
              if (rd_bad) begin
                res_next.status = ST_RANGE;
                res_next.rdval  = '1;
                state_next      = S_DONE;
              end else begin
                mem_raddr  = AW'(in_pos_x - PW'(1));
                state_next = S_READ;
              end
            end
            ACT_LOCATE: begin
              if (count == '0) begin
                res_next.status = ST_MISSING;
                state_next      = S_DONE;
              end else begin
                mem_raddr  = '0;
                idx_next   = '0;
                state_next = S_SCAN;
              end
            end
            ACT_INSERT: begin
              if (full) begin
                res_next.status = ST_FULL;
                state_next      = S_DONE;
              end else if (ins_bad) begin
                res_next.status = ST_RANGE;
                state_next      = S_DONE;
              end else if (in_pos_x == cnt_x + PW'(1)) begin
                state_next = S_PUT;
              end else begin
                // Shift up from the tail down to the insert point.
                mem_raddr  = AW'(cnt_x - PW'(1));
                idx_next   = AW'(cnt_x - PW'(1));
                state_next = S_MOVE;
              end
            end
            ACT_DELETE: begin
              if (rd_bad) begin
                res_next.status = ST_RANGE;
                state_next      = S_DONE;
              end else if (in_pos_x == cnt_x) begin
                count_next = count - CW'(1);
                state_next = S_DONE;
              end else begin
                // Shift down from the entry after the hole to the tail.
                mem_raddr  = AW'(in_pos_x);
                idx_next   = AW'(in_pos_x);
                state_next = S_MOVE;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_READ: begin
        res_next.rdval = VAL_W'($unsigned(mem_rdata));
        state_next     = S_DONE;
      end
      S_SCAN: begin
        // rdata holds entry idx; fetch the next one meanwhile.
        mem_raddr = idx + AW'(1);
        if (mem_rdata == val) begin
          res_next.found = POS_W'(idx_x + PW'(1));
          state_next     = S_DONE;
        end else if (idx_x + PW'(1) == cnt_x) begin
          res_next.status = ST_MISSING;
          state_next      = S_DONE;
        end else begin
          idx_next = idx + AW'(1);
        end
      end
      S_MOVE: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        if (act == ACT_INSERT) begin
          mem_waddr = idx + AW'(1);
          if (idx_x == pos_x - PW'(1)) begin
            state_next = S_PUT;
          end else begin
            idx_next  = idx - AW'(1);
            mem_raddr = idx - AW'(1);
          end
        end else begin
          mem_waddr = idx - AW'(1);
          if (idx_x + PW'(1) == cnt_x) begin
            count_next = count - CW'(1);
            state_next = S_DONE;
          end else begin
            idx_next  = idx + AW'(1);
            mem_raddr = idx + AW'(1);
          end
        end
      end
      S_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = AW'(pos_x - PW'(1));
        mem_wdata  = val;
        count_next = count + CW'(1);
        state_next = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    act <= act_next;
    pos <= pos_next;
    val <= val_next;
    idx <= idx_next;
    res <= res_next;
  end

  `PAL_ASSERT_NOW(a_write_in_list, mem_we, CW'(mem_waddr) <= count, "write beyond list tail")
  `PAL_ASSERT_NEXT(a_count_step, 1'b1, (count == $past(count)) || (count == $past(count) + 1) || (count + 1 == $past(count)), "length moved by more than one")
  `PAL_ASSERT_NOW(a_full_status, res_valid && (res.status == ST_FULL), count == CW'(CAPACITY), "full reported below capacity")
  `PAL_ASSERT_NOW(a_scan_in_list, state == S_SCAN, CW'(idx) < count, "scan past list tail")

endmodule

`default_nettype wire

// File: hw/rtl/positional_array_list.sv
// Positional array list: stream wrapper with result register around the sequencer.
//
// An ordered list of up to CAPACITY entries kept in a single-port-write,
// registered-read memory. One request is taken at a time; s_tready is high
// only while the sequencer is idle. A read fetches one entry; a locate
// compares entries from the head to a match or the tail; an insert shifts
// entries up from the tail to position p, then writes the value; a delete
// shifts the entries after position p down. Errors and a delete of the last
// entry touch no memory. The sequencer moves or compares one stored entry
// per cycle through the memory's one read and one write port. A result
// waits in the output register, so the next request may enter while it is
// still held by the sink. Entries carry no reset; only the length is cleared.
`default_nettype none

module positional_array_list
  import pal_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // position[6:0], value[38:7], zero pad
  input  wire logic [1:0]  s_tuser,   // action[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [47:0] m_tdata,   // found_position[6:0], read_value[38:7],
                                      // count[45:39], empty_res[46], zero pad
  output logic      [1:0]  m_tuser    // status[1:0]
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic                  res_valid, res_ready;
  result_t               res;
  logic [CW-1:0]         count;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

  result_t          out_res;
  logic [POS_W-1:0] out_count;
  logic             out_empty;
  logic             load;

  pal_seq #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_action   (action_t'(s_tuser)),
    .in_position (s_tdata[6:0]),
    .in_value    (s_tdata[38:7]),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .count       (count),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  pal_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Take a finished result whenever the output slot is free or draining.
  assign res_ready = !m_tvalid || m_tready;
  assign load      = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (load) begin
      out_res   <= res;
      out_count <= POS_W'(count);
      out_empty <= (count == '0);
    end
  end

  assign m_tdata = {1'b0, out_empty, out_count, out_res.rdval, out_res.found};
  assign m_tuser = out_res.status;

endmodule

`default_nettype wire
